[hdl/transfer_rate_meter_defines.svh]
// assertion macros used by the transfer rate meter datapath
`ifndef TRANSFER_RATE_METER_DEFINES_SVH
`define TRANSFER_RATE_METER_DEFINES_SVH

// same-cycle implication, clocked on clock and disabled in reset
`define TRM_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TRM_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/trm_pkg.sv]
// types and constants of the transfer rate meter
`default_nettype none

package trm_pkg;

   localparam int TICK_W  = 32;
   localparam int BYTES_W = 48;
   localparam int SPEED_W = 56;
   localparam int DVD_W   = 72;
   localparam int MUL_STEPS = 16;

   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_QUERY  = 2'd1,
      OP_RESET  = 2'd2
   } op_type;

   localparam logic [1:0] CSR_WINDOW = 2'd0;
   localparam logic [1:0] CSR_STALE  = 2'd1;
   localparam logic [1:0] CSR_BLEND  = 2'd2;

   localparam logic [15:0] WINDOW_RESET = 16'd5000;
   localparam logic [15:0] STALE_RESET  = 16'd2500;
   localparam logic [2:0]  BLEND_RESET  = 3'd2;

   localparam logic [1:0] FRESH_NOW    = 2'd0;
   localparam logic [1:0] FRESH_FADING = 2'd1;
   localparam logic [1:0] FRESH_IDLE   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_READ_OLD,
      S_CHECK_OLD,
      S_DIVIDE,
      S_BLEND,
      S_QUERY,
      S_MULTIPLY,
      S_RESULT
   } state_type;

   typedef struct packed {
      logic accept;
      logic clear;
      logic refresh;
      logic append;
      logic drop;
      logic finish;
      logic div_start_rate;
      logic div_start_query;
      logic step;
      logic blend;
      logic set_res;
      logic mul_start;
      logic res_fade;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic is_update;
      logic is_query;
      logic is_reset;
      logic same_bytes;
      logic prune;
      logic rate_ok;
      logic busy;
      logic q_direct;
      logic rsp_free;
   } status_type;

endpackage

`default_nettype wire

[hdl/transfer_rate_meter.sv]
// Transfer rate meter top level. One transaction is worked on at a time. A query
// that has to fade the speed runs a 16-step serial multiply, then a 72-step
// restoring divider, one quotient bit per cycle; a query answered without fading
// goes straight to the result. An update that appends a sample and yields a rate
// does one ring read per pruned sample, then runs the same divider; without a
// rate it does only the ring reads, one per pruned sample. An update with an
// unchanged count, a reset and an unused op finish in the dispatch state. A
// finished result sits in an output register, so the next transaction is taken
// while it waits. Samples live in one ram with registered read; entries are only
// read after being written, so no clearing pass is needed.
`default_nettype none

module transfer_rate_meter #(
   parameter int SAMPLE_DEPTH = 64
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [79:0] req_tdata,   // tick [31:0], cumulative_bytes [79:32]
   input  wire logic [1:0]  req_tuser,   // op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // speed
   output logic [1:0]       rsp_tuser,   // freshness
   input  wire logic        csr_we,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   import trm_pkg::*;

   cmd_type    cmd;
   status_type status;

   trm_datapath #(.SAMPLE_DEPTH(SAMPLE_DEPTH)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .status     (status)
   );

   trm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

endmodule

`default_nettype wire

[hdl/trm_ram.sv]
// generic single-port-write ram with registered read
`default_nettype none

module trm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire

[hdl/trm_datapath.sv]
// sample ring, shared divider and multiplier, speed and result registers
`default_nettype none
`include "transfer_rate_meter_defines.svh"

module trm_datapath #(
   parameter int SAMPLE_DEPTH = 64
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic [79:0]         req_tdata,
   input  wire logic [1:0]          req_tuser,
   input  wire logic                csr_we,
   input  wire logic [1:0]          csr_index,
   input  wire logic [15:0]         csr_wdata,
   input  wire logic                rsp_tready,
   output logic                     rsp_tvalid,
   output logic [55:0]              rsp_tdata,
   output logic [1:0]               rsp_tuser,
   input  wire trm_pkg::cmd_type    cmd,
   output trm_pkg::status_type      status
);

   import trm_pkg::*;

   localparam int AW = $clog2(SAMPLE_DEPTH);
   localparam int CW = $clog2(SAMPLE_DEPTH + 1);
   localparam logic [CW:0]   DEPTH_X   = (CW + 1)'(SAMPLE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C   = CW'(SAMPLE_DEPTH);
   localparam logic [AW-1:0] LAST_SLOT = AW'(SAMPLE_DEPTH - 1);
   localparam logic [CW-1:0] TWO       = CW'(2);

   logic [15:0]          window_ff, window_in;
   logic [15:0]          stale_ff, stale_in;
   logic [2:0]           shift_ff, shift_in;
   logic [1:0]           op_ff;
   logic [TICK_W-1:0]    tick_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [AW-1:0]        head_ff, head_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [AW-1:0]        newest_slot_ff;
   logic [TICK_W-1:0]    newest_tick_ff, newest_tick_in;
   logic [BYTES_W-1:0]   newest_bytes_ff;
   logic [SPEED_W-1:0]   smooth_ff, smooth_in;
   logic [TICK_W-1:0]    last_ff, last_in;
   logic [DVD_W-1:0]     dvd_ff, dvd_in;
   logic [31:0]          rem_ff, rem_in;
   logic [31:0]          dvs_ff, dvs_in;
   logic [6:0]           step_ff, step_in;
   logic [15:0]          mulf_ff, mulf_in;
   logic [SPEED_W-1:0]   res_speed_ff, res_speed_in;
   logic [1:0]           res_fresh_ff, res_fresh_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SPEED_W-1:0]   rsp_speed_ff;
   logic [1:0]           rsp_fresh_ff;

   logic [79:0]          rd_data;
   logic [TICK_W-1:0]    old_tick;
   logic [BYTES_W-1:0]   old_bytes;
   logic                 lower, full;
   logic [AW-1:0]        head_inc, app_slot, wr_addr;
   logic [CW:0]          slot_sum, slot_wrap;
   logic [TICK_W-1:0]    age, dt, idle;
   logic [BYTES_W-1:0]   db;
   logic [57:0]          db_x, scaled;
   logic [32:0]          trial;
   logic                 ge;
   logic [SPEED_W-1:0]   rate, blended;
   logic [63:0]          mix;
   logic                 never, fresh, gone;
   logic [16:0]          stale2;

   assign old_tick  = rd_data[TICK_W-1:0];
   assign old_bytes = rd_data[79:TICK_W];

   trm_ram #(.WIDTH(80), .DEPTH(SAMPLE_DEPTH)) u_samples (
      .clock   (clock),
      .wr_en   (cmd.append | cmd.refresh),
      .wr_addr (wr_addr),
      .wr_data ({bytes_ff, tick_ff}),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      lower     = (count_ff != '0) && (bytes_ff < newest_bytes_ff);
      full      = count_ff == DEPTH_C;
      head_inc  = (head_ff == LAST_SLOT) ? '0 : head_ff + 1'b1;
      slot_sum  = (CW + 1)'(head_ff) + (CW + 1)'(count_ff);
      slot_wrap = (slot_sum >= DEPTH_X) ? slot_sum - DEPTH_X : slot_sum;
      if (lower) begin
         app_slot = '0;
      end else if (full) begin
         app_slot = head_ff;
      end else begin
         app_slot = slot_wrap[AW-1:0];
      end
      wr_addr = cmd.refresh ? newest_slot_ff : app_slot;

      age    = tick_ff - old_tick;
      dt     = newest_tick_ff - old_tick;
      db     = newest_bytes_ff - old_bytes;
      db_x   = 58'(db);
      scaled = (db_x << 10) - (db_x << 5) + (db_x << 3);

      trial = {rem_ff, dvd_ff[DVD_W-1]};
      ge    = trial >= {1'b0, dvs_ff};

      rate    = (dvd_ff[DVD_W-1:SPEED_W] != '0) ? '1 : dvd_ff[SPEED_W-1:0];
      mix     = (64'(smooth_ff) << shift_ff) - 64'(smooth_ff) + 64'(rate);
      blended = SPEED_W'(mix >> shift_ff);

      idle   = tick_ff - last_ff;
      stale2 = {stale_ff, 1'b0};
      never  = (smooth_ff == '0) || (last_ff == '0);
      fresh  = idle <= 32'(stale_ff);
      gone   = idle >= 32'(stale2);
   end

   always_comb begin
      status.is_update  = op_ff == OP_UPDATE;
      status.is_query   = op_ff == OP_QUERY;
      status.is_reset   = op_ff == OP_RESET;
      status.same_bytes = (count_ff != '0) && (bytes_ff == newest_bytes_ff);
      status.prune      = (count_ff > TWO) && (age > 32'(window_ff));
      status.rate_ok    = (count_ff >= TWO) && (dt != '0) && (newest_bytes_ff > old_bytes);
      status.busy       = step_ff != '0;
      status.q_direct   = never || fresh || gone;
      status.rsp_free   = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      window_in      = window_ff;
      stale_in       = stale_ff;
      shift_in       = shift_ff;
      head_in        = head_ff;
      count_in       = count_ff;
      newest_tick_in = newest_tick_ff;
      smooth_in      = smooth_ff;
      last_in        = last_ff;
      dvd_in         = dvd_ff;
      rem_in         = rem_ff;
      dvs_in         = dvs_ff;
      step_in        = step_ff;
      mulf_in        = mulf_ff;
      res_speed_in   = res_speed_ff;
      res_fresh_in   = res_fresh_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;

      if (csr_we) begin
         case (csr_index)
            CSR_WINDOW: window_in = csr_wdata;
            CSR_STALE:  stale_in  = csr_wdata;
            CSR_BLEND:  shift_in  = csr_wdata[2:0];
            default:    ;
         endcase
      end

      if (cmd.clear) begin
         head_in   = '0;
         count_in  = '0;
         smooth_in = '0;
         last_in   = '0;
      end
      if (cmd.refresh) begin
         newest_tick_in = tick_ff;
         last_in        = tick_ff;
      end
      if (cmd.append) begin
         newest_tick_in = tick_ff;
         if (lower) begin
            head_in   = '0;
            count_in  = CW'(1);
            smooth_in = '0;
         end else if (full) begin
            head_in = head_inc;
         end else begin
            count_in = count_ff + 1'b1;
         end
      end
      if (cmd.drop) begin
         head_in  = head_inc;
         count_in = count_ff - 1'b1;
      end
      if (cmd.finish) begin
         last_in = tick_ff;
      end
      if (cmd.div_start_rate) begin
         dvd_in  = {6'b0, scaled, 8'b0};
         dvs_in  = dt;
         rem_in  = '0;
         step_in = 7'(DVD_W);
      end
      if (cmd.mul_start) begin
         dvd_in  = '0;
         mulf_in = 16'(stale2 - idle[16:0]);
         step_in = 7'(MUL_STEPS);
      end
      if (cmd.div_start_query) begin
         dvs_in  = 32'(stale_ff);
         rem_in  = '0;
         step_in = 7'(DVD_W);
      end
      if (cmd.step) begin
         step_in = step_ff - 1'b1;
      end
      if (cmd.blend) begin
         smooth_in = (smooth_ff == '0) ? rate : blended;
         last_in   = tick_ff;
      end
      if (cmd.set_res) begin
         if (never || !fresh) begin
            res_speed_in = '0;
            res_fresh_in = FRESH_IDLE;
         end else begin
            res_speed_in = smooth_ff;
            res_fresh_in = FRESH_NOW;
         end
      end
      if (cmd.res_fade) begin
         res_speed_in = dvd_ff[SPEED_W-1:0];
         res_fresh_in = FRESH_FADING;
      end
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end
   end

   // one shared shift register: multiplier steps accumulate, divider steps restore
   logic mul_phase_ff, mul_phase_in;

   always_comb begin
      mul_phase_in = mul_phase_ff;
      if (cmd.mul_start) begin
         mul_phase_in = 1'b1;
      end else if (cmd.div_start_query || cmd.div_start_rate) begin
         mul_phase_in = 1'b0;
      end
   end

   logic [DVD_W-1:0] dvd_step;
   logic [31:0]      rem_step;
   logic [15:0]      mulf_step;

   always_comb begin
      dvd_step  = dvd_in;
      rem_step  = rem_in;
      mulf_step = mulf_in;
      if (cmd.step) begin
         if (mul_phase_ff) begin
            dvd_step  = (dvd_ff << 1) + (mulf_ff[15] ? DVD_W'(smooth_ff) : '0);
            mulf_step = {mulf_ff[14:0], 1'b0};
         end else begin
            rem_step = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
            dvd_step = {dvd_ff[DVD_W-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         stale_ff     <= STALE_RESET;
         shift_ff     <= BLEND_RESET;
         head_ff      <= '0;
         count_ff     <= '0;
         smooth_ff    <= '0;
         last_ff      <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         mul_phase_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         stale_ff     <= stale_in;
         shift_ff     <= shift_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         smooth_ff    <= smooth_in;
         last_ff      <= last_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
         mul_phase_ff <= mul_phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff    <= req_tuser;
         tick_ff  <= req_tdata[TICK_W-1:0];
         bytes_ff <= req_tdata[79:TICK_W];
      end
      if (cmd.append) begin
         newest_slot_ff  <= app_slot;
         newest_bytes_ff <= bytes_ff;
      end
      newest_tick_ff <= newest_tick_in;
      dvd_ff         <= dvd_step;
      rem_ff         <= rem_step;
      dvs_ff         <= dvs_in;
      mulf_ff        <= mulf_step;
      res_speed_ff   <= res_speed_in;
      res_fresh_ff   <= res_fresh_in;
      if (cmd.emit) begin
         rsp_speed_ff <= res_speed_ff;
         rsp_fresh_ff <= res_fresh_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_speed_ff;
   assign rsp_tuser  = rsp_fresh_ff;

   `TRM_ASSERT_IMPL(a_count_bound, 1'b1, count_ff <= DEPTH_C, "ring count above depth")
   `TRM_ASSERT_IMPL(a_emit_free, cmd.emit, !rsp_valid_ff || rsp_tready, "pending result overwritten")
   `TRM_ASSERT_NEXT(a_append_fill, cmd.append, count_ff != '0, "ring empty after append")
   `TRM_ASSERT_IMPL(a_rate_divisor, cmd.div_start_rate, dt != '0, "rate division by zero")
   `TRM_ASSERT_IMPL(a_fade_divisor, cmd.div_start_query, stale_ff != '0, "fade division by zero")

endmodule

`default_nettype wire

[hdl/trm_ctrl.sv]
// controller state machine sequencing update, query and reset transactions
`default_nettype none

module trm_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire trm_pkg::status_type status,
   output trm_pkg::cmd_type         cmd
);

   import trm_pkg::*;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (status.is_update) begin
               state_in = status.same_bytes ? S_IDLE : S_READ_OLD;
            end else if (status.is_query) begin
               state_in = S_QUERY;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_READ_OLD: state_in = S_CHECK_OLD;
         S_CHECK_OLD: begin
            if (status.prune) begin
               state_in = S_READ_OLD;
            end else if (status.rate_ok) begin
               state_in = S_DIVIDE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIVIDE: begin
            if (!status.busy) state_in = status.is_query ? S_RESULT : S_BLEND;
         end
         S_BLEND: state_in = S_IDLE;
         S_QUERY: state_in = status.q_direct ? S_RESULT : S_MULTIPLY;
         S_MULTIPLY: begin
            if (!status.busy) state_in = S_DIVIDE;
         end
         S_RESULT: begin
            if (status.rsp_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            cmd.accept = req_tvalid;
         end
         S_DISPATCH: begin
            if (status.is_update) begin
               cmd.refresh = status.same_bytes;
               cmd.append  = !status.same_bytes;
            end else if (status.is_reset) begin
               cmd.clear = 1'b1;
            end
         end
         S_CHECK_OLD: begin
            if (status.prune) begin
               cmd.drop = 1'b1;
            end else if (status.rate_ok) begin
               cmd.div_start_rate = 1'b1;
            end else begin
               cmd.finish = 1'b1;
            end
         end
         S_DIVIDE: begin
            cmd.step     = status.busy;
            cmd.res_fade = !status.busy && status.is_query;
         end
         S_BLEND: cmd.blend = 1'b1;
         S_QUERY: begin
            cmd.set_res   = status.q_direct;
            cmd.mul_start = !status.q_direct;
         end
         S_MULTIPLY: begin
            cmd.step            = status.busy;
            cmd.div_start_query = !status.busy;
         end
         S_RESULT: cmd.emit = status.rsp_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

[test/transfer_rate_meter_tb.sv]
// self-checking testbench of the transfer rate meter with stream driver and monitor
`default_nettype none

module transfer_rate_meter_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import trm_pkg::*;

   localparam int RING_DEPTH = 64;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [63:0] SPEED_MAX = 64'h00FF_FFFF_FFFF_FFFF;
   localparam int SETTLE_CYCLES = 400;

   typedef struct {
      logic [1:0]  op;
      logic [31:0] tick;
      logic [47:0] bytes;
   } meter_txn_type;

   typedef struct {
      logic [55:0] speed;
      logic [1:0]  fresh;
   } speed_report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [79:0] req_tdata = '0;
   logic [1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_we = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   transfer_rate_meter dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // meter shadow state
   logic [31:0] shadow_ticks [RING_DEPTH];
   logic [47:0] shadow_bytes [RING_DEPTH];
   int unsigned ring_first = 0;
   int unsigned ring_fill = 0;
   logic [63:0] ema_speed = '0;
   logic [31:0] last_tick = '0;
   logic [63:0] window_len = 64'd5000;
   logic [63:0] stale_len = 64'd2500;
   int unsigned ema_shift = 2;

   meter_txn_type pending_txns[$];
   speed_report_type expected_speeds[$];
   meter_txn_type txn_on_bus;
   int send_gap = 0;
   int recv_gap = 0;
   int hold_left = 0;
   logic hold_start = 1'b0;
   bit no_idle = 0;
   int mismatches = 0;

   function automatic meter_txn_type take_txn();
      meter_txn_type txn;
      txn = pending_txns[0];
      pending_txns.delete(0);
      return txn;
   endfunction

   function automatic speed_report_type take_report();
      speed_report_type rep;
      rep = expected_speeds[0];
      expected_speeds.delete(0);
      return rep;
   endfunction

   function automatic int unsigned ring_slot(int unsigned offset);
      return (ring_first + offset) % RING_DEPTH;
   endfunction

   function automatic logic [63:0] window_rate(logic [63:0] db, logic [63:0] dt);
      logic [63:0] scaled;
      logic [63:0] whole;
      logic [63:0] rem;
      scaled = db * 64'd1000;
      whole = scaled / dt;
      rem = scaled % dt;
      if (whole > 64'h0000_FFFF_FFFF_FFFF) return SPEED_MAX;
      return (whole << 8) | ((rem << 8) / dt);
   endfunction

   function automatic void meter_update(logic [31:0] t, logic [47:0] b);
      int unsigned newest;
      logic [31:0] age;
      logic [63:0] dt;
      logic [63:0] rate;
      if (ring_fill > 0) begin
         newest = ring_slot(ring_fill - 1);
         if (b < shadow_bytes[newest]) begin
            ring_fill = 0;
            ring_first = 0;
            ema_speed = '0;
         end else if (b == shadow_bytes[newest]) begin
            shadow_ticks[newest] = t;
            last_tick = t;
            return;
         end
      end
      if (ring_fill >= RING_DEPTH) begin
         ring_first = ring_slot(1);
         ring_fill--;
      end
      newest = ring_slot(ring_fill);
      shadow_ticks[newest] = t;
      shadow_bytes[newest] = b;
      ring_fill++;
      age = t - shadow_ticks[ring_first];
      while (ring_fill > 2 && {32'd0, age} > window_len) begin
         ring_first = ring_slot(1);
         ring_fill--;
         age = t - shadow_ticks[ring_first];
      end
      if (ring_fill >= 2) begin
         newest = ring_slot(ring_fill - 1);
         dt = {32'd0, shadow_ticks[newest] - shadow_ticks[ring_first]};
         if (dt != 0 && shadow_bytes[newest] > shadow_bytes[ring_first]) begin
            rate = window_rate({16'd0, shadow_bytes[newest] - shadow_bytes[ring_first]}, dt);
            if (ema_speed == 0)
               ema_speed = rate;
            else
               ema_speed = (ema_speed * ((64'd1 << ema_shift) - 1) + rate) >> ema_shift;
         end
      end
      last_tick = t;
   endfunction

   function automatic speed_report_type meter_query(logic [31:0] t);
      speed_report_type rep;
      logic [63:0] idle;
      logic [63:0] f;
      logic [63:0] fade;
      idle = {32'd0, t - last_tick};
      rep.speed = '0;
      rep.fresh = FRESH_IDLE;
      if (ema_speed == 0 || last_tick == 0) return rep;
      if (idle <= stale_len) begin
         rep.speed = ema_speed[55:0];
         rep.fresh = FRESH_NOW;
      end else if (idle < 2 * stale_len) begin
         f = 2 * stale_len - idle;
         fade = (ema_speed / stale_len) * f + ((ema_speed % stale_len) * f) / stale_len;
         rep.speed = fade[55:0];
         rep.fresh = FRESH_FADING;
      end
      return rep;
   endfunction

   function automatic void meter_apply(meter_txn_type txn);
      case (txn.op)
         OP_UPDATE: meter_update(txn.tick, txn.bytes);
         OP_QUERY: expected_speeds.push_back(meter_query(txn.tick));
         OP_RESET: begin
            ring_fill = 0;
            ring_first = 0;
            ema_speed = '0;
            last_tick = '0;
         end
         default: ;
      endcase
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) meter_apply(txn_on_bus);
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0 || pending_txns.size() == 0) begin
               req_tvalid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               txn_on_bus = take_txn();
               req_tvalid <= 1'b1;
               req_tdata <= {txn_on_bus.bytes, txn_on_bus.tick};
               req_tuser <= txn_on_bus.op;
               send_gap = no_idle ? 0 : $urandom_range(0, 12);
            end
         end
      end
   end

   // long receiver hold-off
   always @(posedge clock) begin
      if (hold_start) hold_left <= 3000;
      else if (hold_left > 0) hold_left <= hold_left - 1;
   end

   // response monitor
   always @(posedge clock) begin
      speed_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_speeds.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected transaction: speed %h freshness %0d", rsp_tdata, rsp_tuser);
            end else begin
               want = take_report();
               if (rsp_tdata !== want.speed || rsp_tuser !== want.fresh) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("speed exp %h got %h, freshness exp %0d got %0d",
                              want.speed, rsp_tdata, want.fresh, rsp_tuser);
               end
            end
            recv_gap = no_idle ? 0 : $urandom_range(0, 12);
         end
         if (recv_gap > 0) recv_gap--;
         rsp_tready <= (recv_gap == 0) && (hold_left <= 1) && !hold_start;
      end
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] value);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_WINDOW: window_len = {48'd0, value};
         CSR_STALE: stale_len = {48'd0, value};
         CSR_BLEND: ema_shift = value[2:0];
         default: ;
      endcase
   endtask

   task automatic configure(logic [15:0] win, logic [15:0] stl, logic [2:0] shf);
      write_reg(CSR_WINDOW, win);
      write_reg(CSR_STALE, stl);
      write_reg(CSR_BLEND, {13'd0, shf});
   endtask

   task automatic push_txn(logic [1:0] op, logic [31:0] t, logic [47:0] b);
      meter_txn_type txn;
      txn.op = op;
      txn.tick = t;
      txn.bytes = b;
      pending_txns.push_back(txn);
   endtask

   task automatic drain();
      while (pending_txns.size() != 0 || req_tvalid || expected_speeds.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // well-formed transfer streams with random content and some noise
   task automatic push_random(int count, int step_max);
      logic [31:0] t;
      logic [47:0] b;
      logic [47:0] inc;
      int pick;
      t = $urandom;
      b = {16'($urandom_range(0, 65535)), 32'($urandom)};
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            t = t + $urandom_range(0, step_max);
            case ($urandom_range(0, 9))
               0, 1: inc = '0;
               2: inc = {16'($urandom_range(0, 4095)), 32'($urandom)};
               3: inc = 48'($urandom_range(0, 3));
               default: inc = 48'($urandom_range(1, 200000));
            endcase
            if ($urandom_range(0, 39) == 0) b = b >> $urandom_range(1, 20);
            else if (b + inc < b) b = 48'($urandom);
            else b = b + inc;
            push_txn(OP_UPDATE, t, b);
         end else if (pick < 88) begin
            push_txn(OP_QUERY, t + $urandom_range(0, 3 * int'(stale_len)), 48'($urandom));
         end else if (pick < 91) begin
            push_txn(OP_RESET, $urandom, {16'($urandom_range(0, 65535)), 32'($urandom)});
         end else if (pick < 94) begin
            push_txn(OP_UNUSED, $urandom, {16'($urandom_range(0, 65535)), 32'($urandom)});
         end else if (pick < 97) begin
            t = t + $urandom_range(0, 2 * int'(window_len));
         end else begin
            t = $urandom;
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset configuration
      push_txn(OP_QUERY, 32'd100, 48'd0);
      push_txn(OP_UPDATE, 32'd0, 48'd10);
      push_txn(OP_UPDATE, 32'd10, 48'd5000);
      push_txn(OP_QUERY, 32'd20, 48'd0);
      push_txn(OP_UPDATE, 32'd30, 48'd9000);
      push_txn(OP_QUERY, 32'd40, 48'd0);
      push_txn(OP_UPDATE, 32'd50, 48'd9000);
      push_txn(OP_QUERY, 32'd2000, 48'd0);
      push_txn(OP_QUERY, 32'd4000, 48'd0);
      push_txn(OP_QUERY, 32'd5050, 48'd0);
      push_txn(OP_QUERY, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      push_txn(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      push_txn(OP_QUERY, 32'd60, 48'd0);
      push_txn(OP_UPDATE, 32'd70, 48'd100);
      push_txn(OP_QUERY, 32'd80, 48'd0);
      push_txn(OP_UPDATE, 32'hFFFF_FFFE, 48'd0);
      push_txn(OP_UPDATE, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
      push_txn(OP_QUERY, 32'd0, 48'd0);
      push_txn(OP_UPDATE, 32'd10000, 48'hFFFF_FFFF_FFFF);
      push_txn(OP_RESET, 32'd0, 48'd0);
      push_txn(OP_QUERY, 32'd10001, 48'd0);
      drain();

      // full ring and pruning at the extremes
      configure(16'hFFFF, 16'hFFFF, 3'd7);
      for (int k = 0; k < 70; k++) push_txn(OP_UPDATE, 32'(1000 + 3 * k), 48'(k * k * 77 + 1));
      push_txn(OP_QUERY, 32'd1300, 48'd0);
      drain();
      configure(16'd1, 16'd1, 3'd0);
      for (int k = 0; k < 70; k++) push_txn(OP_UPDATE, 32'(5 + k), 48'(k * 1000 + 1));
      push_txn(OP_QUERY, 32'd75, 48'd0);
      push_txn(OP_QUERY, 32'd76, 48'd0);
      push_txn(OP_QUERY, 32'd78, 48'd0);
      drain();

      // input stalls while the receiver holds off
      configure(16'd5000, 16'd2500, 3'd2);
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
      push_random(60, 100);
      drain();

      configure(16'd5000, 16'd2500, 3'd2);
      push_random(300, 100);
      drain();
      configure(16'd1, 16'd1, 3'd0);
      push_random(200, 3);
      drain();
      configure(16'hFFFF, 16'hFFFF, 3'd7);
      push_random(250, 2000);
      drain();
      no_idle = 1;
      configure(16'd100, 16'd50, 3'd3);
      push_random(250, 20);
      drain();
      no_idle = 0;
      for (int p = 0; p < 4; p++) begin
         configure(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)),
                   3'($urandom_range(0, 7)));
         push_random(200, int'($urandom_range(1, 5000)));
         drain();
      end

      if (mismatches == 0 && expected_speeds.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+hdl
hdl/trm_pkg.sv
hdl/trm_ram.sv
hdl/trm_datapath.sv
hdl/trm_ctrl.sv
hdl/transfer_rate_meter.sv
test/transfer_rate_meter_tb.sv
